@@ hdl/complex_dirichlet_elimination_macros.svh @@
//----------------------------------------------------------------------------
// complex_dirichlet_elimination assertion macros
// concurrent checks on clk with rst_n held low masking them
//----------------------------------------------------------------------------
`ifndef COMPLEX_DIRICHLET_ELIMINATION_MACROS_SVH
`define COMPLEX_DIRICHLET_ELIMINATION_MACROS_SVH
`ifndef SYNTHESIS
`define CDE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CDE_ASSERT_IMPL(lbl, ante, cons, msg)
`define CDE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/cde_pkg.sv @@
//----------------------------------------------------------------------------
// cde_pkg
// shared types and codes of the dirichlet elimination block
//----------------------------------------------------------------------------
package cde_pkg;

  localparam int DOF_SPACE = 1024;
  localparam int RHS_SPACE = 4;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // classified operation codes
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_LOAD  = 3'd2;
  localparam logic [2:0] OP_ENTRY = 3'd3;
  localparam logic [2:0] OP_DIAG  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // raw function codes at the port
  localparam logic [2:0] FN_SET   = 3'd0;
  localparam logic [2:0] FN_LOAD  = 3'd1;
  localparam logic [2:0] FN_ENTRY = 3'd2;
  localparam logic [2:0] FN_DIAG  = 3'd3;
  localparam logic [2:0] FN_READ  = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [9:0]         dof;
    logic [9:0]         col;
    logic [1:0]         sel;
    logic               flag;
    logic signed [31:0] v_re;
    logic signed [31:0] v_im;
    logic signed [31:0] u_re;
    logic signed [31:0] u_im;
  } item_t;

endpackage

@@ hdl/cde_ram.sv @@
//----------------------------------------------------------------------------
// cde_ram
// generic one write, one read ram with registered read data
//----------------------------------------------------------------------------
module cde_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/cde_front.sv @@
//----------------------------------------------------------------------------
// cde_front
// takes requests, range checks and classifies them, queues them for the back
//----------------------------------------------------------------------------
module cde_front #(
  parameter int DOF_COUNT = 1024,
  parameter int RHS_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [9:0]         in_dof_index,
  input  logic [9:0]         in_col_index,
  input  logic [1:0]         in_rhs_sel,
  input  logic               in_bound_flag,
  input  logic signed [31:0] in_value_re,
  input  logic signed [31:0] in_value_im,
  input  logic signed [31:0] in_upper_re,
  input  logic signed [31:0] in_upper_im,
  input  logic               busy,
  output logic               q_valid,
  output cde_pkg::item_t     q_item,
  input  logic               q_pop
);

  cde_pkg::item_t fifo_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic           dof_ok, col_ok, sel_ok;
  cde_pkg::item_t cls;

  assign dof_ok = 32'(in_dof_index) < DOF_COUNT;
  assign col_ok = 32'(in_col_index) < DOF_COUNT;
  assign sel_ok = 32'(in_rhs_sel) < RHS_COUNT;

  always_comb begin
    cls.dof  = in_dof_index;
    cls.col  = in_col_index;
    cls.sel  = in_rhs_sel;
    cls.flag = in_bound_flag;
    cls.v_re = in_value_re;
    cls.v_im = in_value_im;
    cls.u_re = in_upper_re;
    cls.u_im = in_upper_im;
    cls.op   = cde_pkg::OP_NOP;
    case (in_func)
      cde_pkg::FN_SET:   if (dof_ok) cls.op = cde_pkg::OP_SET;
      cde_pkg::FN_LOAD:  if (dof_ok && sel_ok) cls.op = cde_pkg::OP_LOAD;
      cde_pkg::FN_ENTRY: if (dof_ok && col_ok) cls.op = cde_pkg::OP_ENTRY;
      cde_pkg::FN_DIAG:  if (dof_ok) cls.op = cde_pkg::OP_DIAG;
      cde_pkg::FN_READ:  if (dof_ok && sel_ok) cls.op = cde_pkg::OP_READ;
      default:           cls.op = cde_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2) || busy;
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ hdl/cde_back.sv @@
//----------------------------------------------------------------------------
// cde_back
// sequencer that looks up bound state, accumulates corrections, builds results
//----------------------------------------------------------------------------
`include "complex_dirichlet_elimination_macros.svh"
module cde_back #(
  parameter int DOF_COUNT = 1024,
  parameter int RHS_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cde_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_first_re,
  output logic signed [31:0] out_first_im,
  output logic signed [31:0] out_second_re,
  output logic signed [31:0] out_second_im
);

  localparam int DOF_DEPTH = (DOF_COUNT < cde_pkg::DOF_SPACE) ? DOF_COUNT : cde_pkg::DOF_SPACE;
  localparam int RHS_N     = (RHS_COUNT < cde_pkg::RHS_SPACE) ? RHS_COUNT : cde_pkg::RHS_SPACE;
  localparam int RHS_DEPTH = RHS_N * DOF_DEPTH;
  localparam int AW        = $clog2(DOF_DEPTH);
  localparam int RW        = (RHS_DEPTH > 1) ? $clog2(RHS_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic signed [49:0] C48_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] C48_MIN = -50'sd140737488355328;
  localparam logic signed [48:0] C32_MAX = 49'sd2147483647;
  localparam logic signed [48:0] C32_MIN = -49'sd2147483648;

  logic [2:0]     st_r, st_nxt;
  cde_pkg::item_t it_r;
  logic           clearing_r;
  logic [AW-1:0]  clr_addr_r;

  logic signed [63:0] pr_rr_r, pr_ii_r, pr_ri_r, pr_ir_r;
  logic signed [48:0] t_re_r, t_im_r;
  logic [AW-1:0]      tgt_r;
  logic signed [31:0] res0_r, res1_r, res2_r, res3_r;
  logic signed [31:0] res0_nxt, res1_nxt, res2_nxt, res3_nxt;
  logic               out_valid_r;
  logic signed [31:0] o0_r, o1_r, o2_r, o3_r;

  logic [64:0] bnd_a_rd, bnd_b_rd, bnd_wd;
  logic [95:0] corr_rd, corr_wd;
  logic [63:0] rhs_rd;
  logic        bnd_we, corr_we, corr_re, rhs_we;
  logic [AW-1:0] bnd_waddr, corr_waddr, corr_raddr;
  logic [RW-1:0] rhs_raddr, rhs_waddr;

  logic               rb, cb, prod_go;
  logic signed [31:0] a_re, a_im, b_re, b_im;
  logic signed [65:0] s_re, s_im;
  logic signed [49:0] d_re, d_im;
  logic signed [47:0] n_re, n_im;
  logic signed [48:0] r_re, r_im;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > C48_MAX) return 48'(C48_MAX);
    if (v < C48_MIN) return 48'(C48_MIN);
    return 48'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > C32_MAX) return 32'(C32_MAX);
    if (v < C32_MIN) return 32'(C32_MIN);
    return 32'(v);
  endfunction

  assign q_pop = q_valid && (st_r == ST_IDLE) && !clearing_r;
  assign busy  = clearing_r;

  assign rhs_raddr = RW'(32'(q_item.sel) * DOF_DEPTH + 32'(q_item.dof));
  assign rhs_waddr = RW'(32'(it_r.sel) * DOF_DEPTH + 32'(it_r.dof));

  assign bnd_we    = clearing_r || (st_r == ST_LOOK && it_r.op == cde_pkg::OP_SET);
  assign bnd_waddr = clearing_r ? clr_addr_r : it_r.dof[AW-1:0];
  assign bnd_wd    = clearing_r ? 65'd0 : {it_r.flag, it_r.v_re, it_r.v_im};

  assign corr_we    = clearing_r || (st_r == ST_ACC);
  assign corr_waddr = clearing_r ? clr_addr_r : tgt_r;
  assign corr_wd    = clearing_r ? 96'd0 : {n_re, n_im};
  assign corr_re    = q_pop || prod_go;
  assign corr_raddr = (st_r == ST_LOOK) ? (rb ? it_r.col[AW-1:0] : it_r.dof[AW-1:0])
                                        : q_item.dof[AW-1:0];

  assign rhs_we = (st_r == ST_LOOK) && (it_r.op == cde_pkg::OP_LOAD);

  cde_ram #(.W(65), .D(DOF_DEPTH)) u_bnd_a (
    .clk(clk), .we(bnd_we), .waddr(bnd_waddr), .wdata(bnd_wd),
    .re(q_pop), .raddr(q_item.dof[AW-1:0]), .rdata(bnd_a_rd)
  );

  cde_ram #(.W(65), .D(DOF_DEPTH)) u_bnd_b (
    .clk(clk), .we(bnd_we), .waddr(bnd_waddr), .wdata(bnd_wd),
    .re(q_pop), .raddr(q_item.col[AW-1:0]), .rdata(bnd_b_rd)
  );

  cde_ram #(.W(96), .D(DOF_DEPTH)) u_corr (
    .clk(clk), .we(corr_we), .waddr(corr_waddr), .wdata(corr_wd),
    .re(corr_re), .raddr(corr_raddr), .rdata(corr_rd)
  );

  cde_ram #(.W(64), .D(RHS_DEPTH)) u_rhs (
    .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata({it_r.v_im, it_r.v_re}),
    .re(q_pop), .raddr(rhs_raddr), .rdata(rhs_rd)
  );

  assign rb = bnd_a_rd[64];
  assign cb = bnd_b_rd[64];
  assign prod_go = (st_r == ST_LOOK) && (it_r.op == cde_pkg::OP_ENTRY) && (rb != cb);

  // row bound: upper times row value into the column; else lower times column value
  assign a_re = rb ? it_r.u_re : it_r.v_re;
  assign a_im = rb ? it_r.u_im : it_r.v_im;
  assign b_re = rb ? bnd_a_rd[63:32] : bnd_b_rd[63:32];
  assign b_im = rb ? bnd_a_rd[31:0]  : bnd_b_rd[31:0];

  assign s_re = 66'(pr_rr_r) - 66'(pr_ii_r) + 66'sd32768;
  assign s_im = 66'(pr_ri_r) + 66'(pr_ir_r) + 66'sd32768;

  assign d_re = 50'($signed(corr_rd[95:48])) - 50'(t_re_r);
  assign d_im = 50'($signed(corr_rd[47:0]))  - 50'(t_im_r);
  assign n_re = sat48(d_re);
  assign n_im = sat48(d_im);

  assign r_re = 49'($signed(rhs_rd[31:0]))  + 49'($signed(corr_rd[95:48]));
  assign r_im = 49'($signed(rhs_rd[63:32])) + 49'($signed(corr_rd[47:0]));

  always_comb begin
    st_nxt   = st_r;
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    res2_nxt = res2_r;
    res3_nxt = res3_r;
    case (st_r)
      ST_IDLE: if (q_pop) st_nxt = ST_LOOK;
      ST_LOOK: begin
        res0_nxt = '0;
        res1_nxt = '0;
        res2_nxt = '0;
        res3_nxt = '0;
        st_nxt   = ST_OUT;
        case (it_r.op)
          cde_pkg::OP_ENTRY: begin
            if (rb != cb) begin
              st_nxt = ST_SUM;
            end else if (!rb) begin
              res0_nxt = it_r.v_re;
              res1_nxt = it_r.v_im;
              res2_nxt = it_r.u_re;
              res3_nxt = it_r.u_im;
            end
          end
          cde_pkg::OP_DIAG: begin
            res0_nxt = rb ? cde_pkg::ONE_Q16 : it_r.v_re;
            res1_nxt = rb ? 32'sd0 : it_r.v_im;
          end
          cde_pkg::OP_READ: begin
            res0_nxt = rb ? bnd_a_rd[63:32] : sat32(r_re);
            res1_nxt = rb ? bnd_a_rd[31:0]  : sat32(r_im);
          end
          default: ;
        endcase
      end
      ST_SUM: st_nxt = ST_ACC;
      ST_ACC: st_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) it_r <= q_item;
    if (prod_go) begin
      pr_rr_r <= a_re * b_re;
      pr_ii_r <= a_im * b_im;
      pr_ri_r <= a_re * b_im;
      pr_ir_r <= a_im * b_re;
      tgt_r   <= rb ? it_r.col[AW-1:0] : it_r.dof[AW-1:0];
    end
    if (st_r == ST_SUM) begin
      t_re_r <= 49'(s_re >>> 16);
      t_im_r <= 49'(s_im >>> 16);
    end
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
    res2_r <= res2_nxt;
    res3_r <= res3_nxt;
    if (st_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      o0_r <= res0_r;
      o1_r <= res1_r;
      o2_r <= res2_r;
      o3_r <= res3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DOF_DEPTH - 1)) clearing_r <= 1'b0;
      end
      if (st_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_first_re  = o0_r;
  assign out_first_im  = o1_r;
  assign out_second_re = o2_r;
  assign out_second_im = o3_r;

  `CDE_ASSERT_IMPL(a_clear_idle, clearing_r, st_r == ST_IDLE && !q_pop, "item taken during clear")
  `CDE_ASSERT_IMPL(a_corr_wr, corr_we, clearing_r || st_r == ST_ACC, "stray correction write")
  `CDE_ASSERT_NEXT(a_sum_acc, st_r == ST_SUM, st_r == ST_ACC, "accumulate step skipped")
  `CDE_ASSERT_IMPL(a_bnd_wr, bnd_we && !clearing_r, it_r.op == cde_pkg::OP_SET, "stray bound write")

endmodule

@@ hdl/complex_dirichlet_elimination.sv @@
// an accepted request passes the front queue, then the back states look and output;
// an entry that updates a correction adds product, rounding, saturating accumulate
// the back sequencer takes a new item only once it has finished with the last one
// reset: synchronous active low; a clearing pass over min(DOF_COUNT,1024)
// addresses then zeroes bound marks and corrections, requests stall meanwhile
//----------------------------------------------------------------------------
// complex_dirichlet_elimination
// symmetric dirichlet elimination over a complex q16.16 sparse matrix
//----------------------------------------------------------------------------
module complex_dirichlet_elimination #(
  parameter int DOF_COUNT = 1024,
  parameter int RHS_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [9:0]         in_dof_index,
  input  logic [9:0]         in_col_index,
  input  logic [1:0]         in_rhs_sel,
  input  logic               in_bound_flag,
  input  logic signed [31:0] in_value_re,
  input  logic signed [31:0] in_value_im,
  input  logic signed [31:0] in_upper_re,
  input  logic signed [31:0] in_upper_im,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_first_re,
  output logic signed [31:0] out_first_im,
  output logic signed [31:0] out_second_re,
  output logic signed [31:0] out_second_im
);

  // queue between front and back
  logic           q_valid, q_pop, busy;
  cde_pkg::item_t q_item;

  // front: range checks, classification, two-entry queue
  cde_front #(.DOF_COUNT(DOF_COUNT), .RHS_COUNT(RHS_COUNT)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_dof_index(in_dof_index), .in_col_index(in_col_index),
    .in_rhs_sel(in_rhs_sel), .in_bound_flag(in_bound_flag),
    .in_value_re(in_value_re), .in_value_im(in_value_im),
    .in_upper_re(in_upper_re), .in_upper_im(in_upper_im),
    .busy(busy), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // back: bound lookup, complex multiply, correction update, output register
  cde_back #(.DOF_COUNT(DOF_COUNT), .RHS_COUNT(RHS_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .busy(busy),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_re(out_first_re), .out_first_im(out_first_im),
    .out_second_re(out_second_re), .out_second_im(out_second_im)
  );

endmodule

@@ tb/testbench.sv @@
//----------------------------------------------------------------------------
// complex_dirichlet_elimination testbench
// drives set/load/entry/diagonal/read requests with random gaps and stalls,
// predicts every result from its own copy of the bound, rhs and correction
// state, and checks each result in order
//----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic signed [31:0] f_re, f_im, s_re, s_im;
  } result_t;

  typedef struct {
    logic [2:0]         func;
    logic [9:0]         dof, col;
    logic [1:0]         sel;
    logic               flag;
    logic signed [31:0] v_re, v_im, u_re, u_im;
  } request_t;

  localparam longint CORR_HI = 64'sd140737488355327;
  localparam longint CORR_LO = -64'sd140737488355328;
  localparam int DOF_USE = 48;
  localparam int DSP = cde_pkg::DOF_SPACE;
  localparam int RSP = cde_pkg::RHS_SPACE;

  // elimination predictor: owns a copy of the block state
  class elim_scoreboard;
    bit                 marked[DSP];
    logic signed [31:0] bval_re[DSP], bval_im[DSP];
    logic signed [31:0] rhs_re[RSP*DSP], rhs_im[RSP*DSP];
    bit                 rhs_seen[RSP*DSP];
    longint             corr_re[DSP], corr_im[DSP];
    result_t            pending[$];
    int                 errors, checked;

    // half-up rounding of (p1 +/- p2) / 2^16, done exactly with 128 bits
    function longint round_q16(longint p1, longint p2, bit sub);
      logic signed [127:0] s;
      s = sub ? ($signed(128'(p1)) - $signed(128'(p2)))
              : ($signed(128'(p1)) + $signed(128'(p2)));
      s = s + 128'sd32768;
      return longint'(s >>> 16);
    endfunction

    function longint clamp48(longint v);
      if (v > CORR_HI) return CORR_HI;
      if (v < CORR_LO) return CORR_LO;
      return v;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // correction[idx] -= a * b (complex)
    function void take_product(int idx, longint ar, longint ai, longint br, longint bi);
      longint tr, ti;
      tr = round_q16(ar * br, ai * bi, 1);
      ti = round_q16(ar * bi, ai * br, 0);
      corr_re[idx] = clamp48(corr_re[idx] - tr);
      corr_im[idx] = clamp48(corr_im[idx] - ti);
    endfunction

    function void note_request(request_t q);
      result_t r;
      int      slot;
      r = '{0, 0, 0, 0};
      slot = q.sel * DSP + q.dof;
      case (q.func)
        cde_pkg::FN_SET: begin
          marked[q.dof] = q.flag;
          bval_re[q.dof] = q.v_re;
          bval_im[q.dof] = q.v_im;
        end
        cde_pkg::FN_LOAD: begin
          rhs_re[slot] = q.v_re;
          rhs_im[slot] = q.v_im;
          rhs_seen[slot] = 1;
        end
        cde_pkg::FN_ENTRY: begin
          if (marked[q.dof] && !marked[q.col])
            take_product(q.col, q.u_re, q.u_im, bval_re[q.dof], bval_im[q.dof]);
          else if (!marked[q.dof] && marked[q.col])
            take_product(q.dof, q.v_re, q.v_im, bval_re[q.col], bval_im[q.col]);
          else if (!marked[q.dof] && !marked[q.col])
            r = '{q.v_re, q.v_im, q.u_re, q.u_im};
        end
        cde_pkg::FN_DIAG: begin
          if (marked[q.dof]) r.f_re = cde_pkg::ONE_Q16;
          else begin
            r.f_re = q.v_re;
            r.f_im = q.v_im;
          end
        end
        cde_pkg::FN_READ: begin
          if (marked[q.dof]) begin
            r.f_re = bval_re[q.dof];
            r.f_im = bval_im[q.dof];
          end else begin
            r.f_re = clamp32(longint'(rhs_re[slot]) + corr_re[q.dof]);
            r.f_im = clamp32(longint'(rhs_im[slot]) + corr_im[q.dof]);
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h %h %h %h", $time,
                 got.f_re, got.f_im, got.s_re, got.s_im);
        return;
      end
      want = pending.pop_front();
      if (got.f_re !== want.f_re) begin
        errors++; $display("%0t first_re exp %h got %h", $time, want.f_re, got.f_re);
      end
      if (got.f_im !== want.f_im) begin
        errors++; $display("%0t first_im exp %h got %h", $time, want.f_im, got.f_im);
      end
      if (got.s_re !== want.s_re) begin
        errors++; $display("%0t second_re exp %h got %h", $time, want.s_re, got.s_re);
      end
      if (got.s_im !== want.s_im) begin
        errors++; $display("%0t second_im exp %h got %h", $time, want.s_im, got.s_im);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [2:0] in_func = 0;
  logic [9:0] in_dof_index = 0, in_col_index = 0;
  logic [1:0] in_rhs_sel = 0;
  logic in_bound_flag = 0;
  logic signed [31:0] in_value_re = 0, in_value_im = 0, in_upper_re = 0, in_upper_im = 0;
  logic signed [31:0] out_first_re, out_first_im, out_second_re, out_second_im;

  elim_scoreboard sb = new();
  longint cycles = 0;
  int sent = 0, n_func[8];
  bit rx_quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  complex_dirichlet_elimination dut (.*);

  // generous limit: clearing pass plus every item at its slowest with long gaps
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sample accepted results at the rising edge
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_first_re, out_first_im, out_second_re, out_second_im});

  // mostly short gaps, now and then a long one
  function int gap_len();
    if ($urandom_range(0, 99) < 30) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall: bursts with no stall at all alternate with random stalls
  always @(negedge clk) begin
    if (rx_quiet || $urandom_range(0, 199) == 0) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 99) < 25);
    if ($urandom_range(0, 299) == 0) rx_quiet <= !rx_quiet;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(request_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_func <= q.func; in_dof_index <= q.dof; in_col_index <= q.col;
    in_rhs_sel <= q.sel; in_bound_flag <= q.flag;
    in_value_re <= q.v_re; in_value_im <= q.v_im;
    in_upper_re <= q.u_re; in_upper_im <= q.u_im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(q);
    sent++;
    n_func[q.func]++;
    @(negedge clk);
  endtask

  // release the request channel and wait until every result is back
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function logic signed [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 131072)) - 65536;
      default: return $urandom();
    endcase
  endfunction

  function request_t mk(logic [2:0] f, int d, int c, int s, bit fl,
                        logic signed [31:0] vr, logic signed [31:0] vi,
                        logic signed [31:0] ur, logic signed [31:0] ui);
    request_t q;
    q = '{f, d[9:0], c[9:0], s[1:0], fl, vr, vi, ur, ui};
    return q;
  endfunction

  // random request, keeping reads away from unwritten rhs entries
  function request_t rnd_request(bit wide);
    request_t q;
    int pick, lim;
    lim = wide ? 1023 : DOF_USE - 1;
    q = mk(cde_pkg::FN_SET, $urandom_range(0, lim), $urandom_range(0, lim),
           $urandom_range(0, 3), 1'($urandom_range(0, 1)),
           rnd_val(), rnd_val(), rnd_val(), rnd_val());
    pick = $urandom_range(0, 99);
    if (pick < 12) q.func = cde_pkg::FN_SET;
    else if (pick < 27) q.func = cde_pkg::FN_LOAD;
    else if (pick < 72) q.func = cde_pkg::FN_ENTRY;
    else if (pick < 80) q.func = cde_pkg::FN_DIAG;
    else if (pick < 97) q.func = cde_pkg::FN_READ;
    else q.func = 3'($urandom_range(5, 7));
    if (q.func == cde_pkg::FN_READ && !sb.marked[q.dof] && !sb.rhs_seen[q.sel*DSP + q.dof])
      q.func = cde_pkg::FN_LOAD;
    return q;
  endfunction

  initial begin
    request_t q;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, every function, each special case
    send(mk(cde_pkg::FN_SET, 0, 0, 0, 1, 32'sh00010000, 32'sh80000000, 0, 0));
    send(mk(cde_pkg::FN_SET, 1023, 0, 0, 1, 32'sh7fffffff, 32'sh7fffffff, 0, 0));
    send(mk(cde_pkg::FN_SET, 5, 0, 0, 0, 0, 0, 0, 0));
    send(mk(cde_pkg::FN_LOAD, 5, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0));
    send(mk(cde_pkg::FN_LOAD, 5, 0, 3, 0, 32'sh00001234, -32'sd7, 0, 0));
    send(mk(cde_pkg::FN_LOAD, 1023, 0, 3, 0, 1, 2, 0, 0));
    // bound row, free column
    send(mk(cde_pkg::FN_ENTRY, 1023, 5, 0, 0, 3, 4, 32'sh7fffffff, 32'sh80000000));
    // free row, bound column
    send(mk(cde_pkg::FN_ENTRY, 5, 0, 0, 0, 32'sh80000000, 32'sh80000000, 9, 9));
    // both bound, both free
    send(mk(cde_pkg::FN_ENTRY, 0, 1023, 0, 0, 7, 7, 7, 7));
    send(mk(cde_pkg::FN_ENTRY, 5, 6, 0, 0, 32'sh80000000, 32'sh7fffffff, -32'sd1, 32'sd1));
    send(mk(cde_pkg::FN_DIAG, 0, 0, 0, 0, 3, 3, 0, 0));
    send(mk(cde_pkg::FN_DIAG, 5, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 0, 0));
    send(mk(cde_pkg::FN_READ, 5, 0, 0, 0, 0, 0, 0, 0));
    send(mk(cde_pkg::FN_READ, 5, 0, 3, 0, 0, 0, 0, 0));
    send(mk(cde_pkg::FN_READ, 1023, 0, 3, 0, 0, 0, 0, 0));
    send(mk(3'd5, 5, 5, 0, 1, 1, 1, 1, 1));
    send(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(3'd7, 1023, 1023, 3, 1, -1, -1, -1, -1));
    // drain everything before continuing
    drain();
    // saturate a correction with repeated large products
    send(mk(cde_pkg::FN_SET, 10, 0, 0, 1, 32'sh7fffffff, 32'sh7fffffff, 0, 0));
    send(mk(cde_pkg::FN_SET, 11, 0, 0, 0, 0, 0, 0, 0));
    send(mk(cde_pkg::FN_LOAD, 11, 0, 1, 0, 0, 0, 0, 0));
    repeat (3) send(mk(cde_pkg::FN_ENTRY, 11, 10, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0));
    send(mk(cde_pkg::FN_READ, 11, 0, 1, 0, 0, 0, 0, 0));

    // random: mostly small dof window so entries hit marked state, a few wide
    for (int i = 0; i < 1200; i++) begin
      q = rnd_request($urandom_range(0, 19) == 0);
      send(q);
      if (i == 600) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d requests: set %0d load %0d entry %0d diag %0d read %0d",
             sent, n_func[0], n_func[1], n_func[2], n_func[3], n_func[4]);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ complex_dirichlet_elimination.f @@
+incdir+hdl
hdl/cde_pkg.sv
hdl/cde_ram.sv
hdl/cde_front.sv
hdl/cde_back.sv
hdl/complex_dirichlet_elimination.sv
tb/testbench.sv
